// File: rtl/core/aslc_pkg.sv
// Shared types, codes and match tables of the archive start line classifier.
// No dependencies; used by the line evaluator, the result queue and the top level.
`timescale 1ns / 1ps
`default_nettype none

package aslc_pkg;

    // Default line limit; a line ends at LINE_MAX - 1 bytes, counted with its newline
    localparam int LINE_MAX_DEFAULT = 512;

    // Configuration register indexes
    localparam logic CFG_KEEP_HEADER       = 1'b0;
    localparam logic CFG_KEEP_MAIL_HEADERS = 1'b1;

    // Classifier phase
    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_CUT    = 2'd1,
        PH_BODY   = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    // Line verdict codes
    typedef enum logic [3:0] {
        V_HEADER         = 4'd0,
        V_CUT            = 4'd1,
        V_BLANK_AFTER    = 4'd2,
        V_SHELL_START    = 4'd3,
        V_BODY           = 4'd4,
        V_C_CODE         = 4'd5,
        V_PASCAL         = 4'd6,
        V_TROFF          = 4'd7,
        V_CUT_LIED       = 4'd8,
        V_NONE           = 4'd9,
        V_NONE_AFTER_CUT = 4'd10,
        V_IGNORED        = 4'd11
    } verdict_t;

    // Words found so far on a line
    localparam int FOUND_CUT  = 0;
    localparam int FOUND_TEAR = 1;
    localparam int FOUND_PAIR = 2;

    // Line prefixes, right-justified strings; C code 0..8, Pascal 9,
    // bare hash 10, shell 11..14, dash marker 15
    localparam logic [71:0] PRE_STR [16] = '{
        "#include", "# include", "#define", "# define", "#ifdef", "# ifdef",
        "#ifndef", "# ifndef", "/*", "(*", "#", ":", "echo ", "sed ", "cat ",
        "--------"
    };
    localparam logic [3:0] PRE_LEN [16] = '{
        4'd8, 4'd9, 4'd7, 4'd8, 4'd6, 4'd7, 4'd7, 4'd8,
        4'd2, 4'd2, 4'd1, 4'd1, 4'd5, 4'd4, 4'd4, 4'd8
    };
    localparam int PRE_C_LAST  = 8;
    localparam int PRE_PASCAL  = 9;
    localparam int PRE_HASH    = 10;
    localparam int PRE_COLON   = 11;
    localparam int PRE_ECHO    = 12;
    localparam int PRE_SED     = 13;
    localparam int PRE_CAT     = 14;
    localparam int PRE_DASHES  = 15;

    // Marker words, right-justified strings
    localparam logic [31:0] WORD_STR [3] = '{"cut", "here", "tear"};
    localparam logic [2:0]  WORD_LEN [3] = '{3'd3, 3'd4, 3'd4};
    localparam int W_CUT  = 0;
    localparam int W_HERE = 1;
    localparam int W_TEAR = 2;

    // Per-line tracking flags
    typedef struct packed {
        logic [15:0] prefix_alive;
        logic        text_only;
        logic [1:0]  troff_state;
        logic [2:0]  word_index;
        logic [2:0]  word_alive;
        logic [2:0]  words_found;
        logic [1:0]  mail_tag_state;
        logic        line_is_blank;
        logic        zero_seen;
        logic        lead_ok;
    } line_st_t;

    localparam line_st_t LINE_CLEAR = '{
        prefix_alive:   16'hFFFF,
        text_only:      1'b1,
        troff_state:    2'd0,
        word_index:     3'd0,
        word_alive:     3'b111,
        words_found:    3'b000,
        mail_tag_state: 2'd0,
        line_is_blank:  1'b1,
        zero_seen:      1'b0,
        lead_ok:        1'b0
    };

    // Outcome of finishing one line
    typedef struct packed {
        verdict_t verdict;
        logic     copy;
        phase_t   phase;
        logic     mail;
    } fin_t;

    // One result item
    typedef struct packed {
        verdict_t verdict;
        logic     copy;
        logic     last;
    } result_t;

    // Results made by one accepted item, packed from entry 0
    typedef struct packed {
        logic [1:0]       count;
        result_t [1:0]    res;
    } push_t;

endpackage

`default_nettype wire

// File: rtl/core/aslc_line_eval.sv
// Line evaluator: per-byte line state and the verdict when a line completes.
// Depends on aslc_pkg for the match tables, state and result types.
`timescale 1ns / 1ps
`default_nettype none

module aslc_line_eval #(
    parameter int LINE_MAX = aslc_pkg::LINE_MAX_DEFAULT
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_accept,
    input  wire logic [7:0]    data_byte,
    input  wire logic          stream_end,
    input  wire logic          new_stream,
    input  wire logic          keep_header,
    input  wire logic          keep_mail_headers,
    output aslc_pkg::push_t    push
);

    localparam int POS_W = $clog2(LINE_MAX);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_MAX - 1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    function automatic logic is_lower(logic [7:0] c);
        return c >= "a" && c <= "z";
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return is_lower(c) || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_tagsym(logic [7:0] c);
        return c == CH_DASH || c == CH_UNDER || c == CH_DOT ||
               (c >= "0" && c <= "9") || is_letter(c);
    endfunction

    function automatic logic is_textsym(logic [7:0] c);
        return is_letter(c) || c == CH_SPACE || c == CH_TAB || c == CH_NL ||
               c == CH_COMMA || c == CH_DOT;
    endfunction

    // Position clipped to four bits; every test looks no further than nine
    function automatic logic [3:0] sat_pos(logic [POS_W-1:0] pos);
        return (pos >= POS_W'(9)) ? 4'd15 : pos[3:0];
    endfunction

    // Close the current word and record cut/here/tear pairs
    function automatic aslc_pkg::line_st_t word_end(aslc_pkg::line_st_t st);
        aslc_pkg::line_st_t s;
        logic w_cut, w_here, w_tear;
        s = st;
        w_cut  = s.word_alive[aslc_pkg::W_CUT]  && s.word_index == aslc_pkg::WORD_LEN[0];
        w_here = s.word_alive[aslc_pkg::W_HERE] && s.word_index == aslc_pkg::WORD_LEN[1];
        w_tear = s.word_alive[aslc_pkg::W_TEAR] && s.word_index == aslc_pkg::WORD_LEN[2];
        if (w_cut) begin
            if (s.words_found[aslc_pkg::FOUND_CUT]) s.words_found[aslc_pkg::FOUND_PAIR] = 1'b1;
            s.words_found[aslc_pkg::FOUND_CUT] = 1'b1;
        end
        if (w_here && (s.words_found[aslc_pkg::FOUND_CUT] ||
                       s.words_found[aslc_pkg::FOUND_TEAR]))
            s.words_found[aslc_pkg::FOUND_PAIR] = 1'b1;
        if (w_tear) s.words_found[aslc_pkg::FOUND_TEAR] = 1'b1;
        s.word_index = 3'd0;
        s.word_alive = 3'b111;
        return s;
    endfunction

    // Fold one visible byte into the line flags
    function automatic aslc_pkg::line_st_t see_byte(aslc_pkg::line_st_t st,
                                                    logic [7:0] b, logic [3:0] p);
        aslc_pkg::line_st_t s;
        logic [7:0] lc;
        logic [3:0] k;
        logic [1:0] j;
        logic       hit;
        s = st;
        // prefix tables
        for (int i = 0; i < 16; i++) begin
            if (p < aslc_pkg::PRE_LEN[i]) begin
                k = aslc_pkg::PRE_LEN[i] - 4'd1 - p;
                if (b != aslc_pkg::PRE_STR[i][{k, 3'b000} +: 8]) s.prefix_alive[i] = 1'b0;
            end
        end
        // troff request: dot, two letters, then a non-letter
        if (p == 4'd0)
            s.troff_state = (b == CH_DOT) ? 2'd1 : 2'd0;
        else if (p == 4'd1)
            s.troff_state = (st.troff_state == 2'd1 && is_letter(b)) ? 2'd2 : 2'd0;
        else if (p == 4'd2)
            s.troff_state = (st.troff_state == 2'd2 && is_letter(b)) ? 2'd3 : 2'd0;
        else if (p == 4'd3 && st.troff_state == 2'd3 && is_letter(b))
            s.troff_state = 2'd0;
        // plain text check
        if (!(p == 4'd0 && b == CH_HASH) && b != CH_NUL && !is_textsym(b))
            s.text_only = 1'b0;
        // mail header tag
        if (st.mail_tag_state == 2'd0)
            s.mail_tag_state = (b == CH_SPACE || b == CH_TAB) ? 2'd2 :
                               (is_tagsym(b) ? 2'd1 : 2'd3);
        else if (st.mail_tag_state == 2'd1)
            s.mail_tag_state = is_tagsym(b) ? 2'd1 : ((b == CH_COLON) ? 2'd2 : 2'd3);
        // marker words, case folded
        if (is_letter(b)) begin
            lc = b | 8'h20;
            for (int i = 0; i < 3; i++) begin
                hit = 1'b0;
                if (s.word_index < aslc_pkg::WORD_LEN[i]) begin
                    j = 2'(aslc_pkg::WORD_LEN[i] - 3'd1 - s.word_index);
                    hit = aslc_pkg::WORD_STR[i][{j, 3'b000} +: 8] == lc;
                end
                if (!hit) s.word_alive[i] = 1'b0;
            end
            if (s.word_index < 3'd7) s.word_index = s.word_index + 3'd1;
        end else begin
            s = word_end(s);
        end
        // first byte of line
        if (p == 4'd0) begin
            s.line_is_blank = (b == CH_NL);
            s.lead_ok = (b == CH_HASH || b == CH_COLON || is_lower(b));
        end
        if (b == CH_NUL) s.zero_seen = 1'b1;
        return s;
    endfunction

    function automatic logic pre_match(aslc_pkg::line_st_t s, logic [3:0] p, int i);
        return s.prefix_alive[i] && p >= aslc_pkg::PRE_LEN[i];
    endfunction

    // Verdict of a completed line
    function automatic aslc_pkg::fin_t finish(aslc_pkg::line_st_t st, logic [3:0] p,
                                              aslc_pkg::phase_t ph, logic mail,
                                              logic keep_h, logic keep_m);
        aslc_pkg::fin_t     f;
        aslc_pkg::line_st_t s;
        logic               c_code;
        s = st;
        if (!s.zero_seen) s = word_end(s);
        f.verdict = aslc_pkg::V_IGNORED;
        f.copy    = 1'b0;
        f.phase   = ph;
        f.mail    = mail;
        c_code = 1'b0;
        for (int i = 0; i <= aslc_pkg::PRE_C_LAST; i++)
            if (pre_match(s, p, i)) c_code = 1'b1;
        unique case (ph)
            aslc_pkg::PH_SEARCH: begin
                if (c_code) begin
                    f.verdict = aslc_pkg::V_C_CODE;
                    f.phase   = aslc_pkg::PH_DONE;
                end else if (pre_match(s, p, aslc_pkg::PRE_PASCAL)) begin
                    f.verdict = aslc_pkg::V_PASCAL;
                    f.phase   = aslc_pkg::PH_DONE;
                end else if (s.troff_state == 2'd3) begin
                    f.verdict = aslc_pkg::V_TROFF;
                    f.phase   = aslc_pkg::PH_DONE;
                end else if ((pre_match(s, p, aslc_pkg::PRE_HASH) && !s.text_only) ||
                             pre_match(s, p, aslc_pkg::PRE_COLON) ||
                             pre_match(s, p, aslc_pkg::PRE_ECHO) ||
                             pre_match(s, p, aslc_pkg::PRE_SED) ||
                             pre_match(s, p, aslc_pkg::PRE_CAT)) begin
                    f.verdict = aslc_pkg::V_SHELL_START;
                    f.phase   = aslc_pkg::PH_BODY;
                end else if (pre_match(s, p, aslc_pkg::PRE_DASHES) ||
                             s.words_found[aslc_pkg::FOUND_PAIR]) begin
                    f.verdict = aslc_pkg::V_CUT;
                    f.phase   = aslc_pkg::PH_CUT;
                end else begin
                    f.verdict = aslc_pkg::V_HEADER;
                    if (keep_h) begin
                        if (mail && s.mail_tag_state != 2'd2) f.mail = 1'b0;
                        f.copy = !f.mail || keep_m;
                    end
                end
            end
            aslc_pkg::PH_CUT: begin
                if (s.line_is_blank) begin
                    f.verdict = aslc_pkg::V_BLANK_AFTER;
                end else if (s.lead_ok) begin
                    f.verdict = aslc_pkg::V_SHELL_START;
                    f.phase   = aslc_pkg::PH_BODY;
                end else begin
                    f.verdict = aslc_pkg::V_CUT_LIED;
                    f.phase   = aslc_pkg::PH_DONE;
                end
            end
            aslc_pkg::PH_BODY: f.verdict = aslc_pkg::V_BODY;
            aslc_pkg::PH_DONE: f.verdict = aslc_pkg::V_IGNORED;
        endcase
        return f;
    endfunction

    aslc_pkg::phase_t   phase_reg, phase_next;
    logic               mail_reg, mail_next;
    aslc_pkg::line_st_t st_reg, st_next;
    logic [POS_W-1:0]   pos_reg, pos_next;

    aslc_pkg::phase_t   eff_phase;
    logic               eff_mail;
    aslc_pkg::line_st_t eff_st, st_b, fin_st;
    logic [POS_W-1:0]   eff_pos, pos_b, fin_pos;
    logic               line_done, has_line, has_end;
    aslc_pkg::phase_t   ph_after;
    aslc_pkg::fin_t     fin;

    // Next state: a new stream clears first, then the byte or the end is taken
    always_comb begin
        eff_phase = new_stream ? aslc_pkg::PH_SEARCH : phase_reg;
        eff_mail  = new_stream ? 1'b1 : mail_reg;
        eff_st    = new_stream ? aslc_pkg::LINE_CLEAR : st_reg;
        eff_pos   = new_stream ? '0 : pos_reg;

        st_b      = eff_st.zero_seen ? eff_st : see_byte(eff_st, data_byte, sat_pos(eff_pos));
        pos_b     = eff_pos + POS_W'(1);
        line_done = data_byte == CH_NL || pos_b >= POS_LAST;

        fin_st  = stream_end ? eff_st : st_b;
        fin_pos = stream_end ? eff_pos : pos_b;
        fin     = finish(fin_st, sat_pos(fin_pos), eff_phase, eff_mail,
                         keep_header, keep_mail_headers);

        has_line = stream_end ? (eff_pos != '0) : line_done;
        ph_after = has_line ? fin.phase : eff_phase;

        phase_next = phase_reg;
        mail_next  = mail_reg;
        st_next    = st_reg;
        pos_next   = pos_reg;
        if (in_accept) begin
            mail_next = has_line ? fin.mail : eff_mail;
            if (stream_end) begin
                phase_next = aslc_pkg::PH_DONE;
                st_next    = aslc_pkg::LINE_CLEAR;
                pos_next   = '0;
            end else if (line_done) begin
                phase_next = fin.phase;
                st_next    = aslc_pkg::LINE_CLEAR;
                pos_next   = '0;
            end else begin
                phase_next = eff_phase;
                st_next    = st_b;
                pos_next   = pos_b;
            end
        end
    end

    // Results of the accepted item, packed from entry 0
    always_comb begin
        has_end = stream_end &&
                  (ph_after == aslc_pkg::PH_SEARCH || ph_after == aslc_pkg::PH_CUT);
        push = '0;
        if (in_accept) begin
            if (has_line) begin
                push.res[0].verdict = fin.verdict;
                push.res[0].copy    = fin.copy;
                push.res[0].last    = !has_end;
                if (has_end) begin
                    push.res[1].verdict = (ph_after == aslc_pkg::PH_SEARCH) ?
                                          aslc_pkg::V_NONE : aslc_pkg::V_NONE_AFTER_CUT;
                    push.res[1].last    = 1'b1;
                end
            end else if (has_end) begin
                push.res[0].verdict = (ph_after == aslc_pkg::PH_SEARCH) ?
                                      aslc_pkg::V_NONE : aslc_pkg::V_NONE_AFTER_CUT;
                push.res[0].last    = 1'b1;
            end
            push.count = 2'({1'b0, has_line} + {1'b0, has_end});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= aslc_pkg::PH_SEARCH;
            mail_reg  <= 1'b1;
            st_reg    <= aslc_pkg::LINE_CLEAR;
            pos_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            mail_reg  <= mail_next;
            st_reg    <= st_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/aslc_result_queue.sv
// Four-entry result queue: takes up to two result items a cycle, gives one while out_ready is high.
// Depends on aslc_pkg for the result and push types.
`timescale 1ns / 1ps
`default_nettype none

module aslc_result_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  aslc_pkg::push_t       push,
    output logic                  room,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output aslc_pkg::result_t     out_res
);

    aslc_pkg::result_t mem_reg [4];
    logic [1:0] wr_reg, wr_next;
    logic [1:0] rd_reg, rd_next;
    logic [2:0] count_reg, count_next;
    logic       pop;

    // Room for the worst case of two results
    assign room      = count_reg <= 3'd2;
    assign out_valid = count_reg != 3'd0;
    assign out_res   = mem_reg[rd_reg];
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_next    = wr_reg + push.count;
        rd_next    = rd_reg + {1'b0, pop};
        count_next = count_reg + {1'b0, push.count} - {2'b00, pop};
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) mem_reg[wr_reg] <= push.res[0];
        if (push.count == 2'd2) mem_reg[wr_reg + 2'd1] <= push.res[1];
    end

    // Pointers and fill
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= 2'd0;
            rd_reg    <= 2'd0;
            count_reg <= 3'd0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/archive_start_line_classifier_unit.sv
// Top level of the archive start line classifier: ports, configuration registers.
// Depends on aslc_pkg, aslc_line_eval and aslc_result_queue.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake            Payload
// s_       in         s_tvalid/s_tready    tdata: data_byte; tuser: stream_end, new_stream
// m_       out        m_tvalid/m_tready    tdata: line_verdict; tuser: copy_to_header;
//                                          tlast: last_of_run
// cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item is accepted per cycle; its results are ready in the queue the next cycle.
// Results leave one per cycle when taken, from a four-entry queue; an end-of-stream
// item can make two, and s_tready drops while fewer than two entries are free.
// aresetn is synchronous and clears all line state; there is no clearing pass.
// cfg_ready is always high; a write counts from the next line verdict.

module archive_start_line_classifier_unit #(
    parameter int LINE_MAX = aslc_pkg::LINE_MAX_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [1:0]  s_tuser,   // [0] stream_end, [1] new_stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [3:0] line_verdict, [7:4] zero
    output logic [0:0]       m_tuser,   // [0] copy_to_header
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [0:0]  cfg_data
);

    logic              keep_header_reg;
    logic              keep_mail_headers_reg;
    logic              room;
    logic              in_accept;
    aslc_pkg::push_t   push;
    aslc_pkg::result_t out_res;

    assign s_tready  = room;
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_header_reg       <= 1'b0;
            keep_mail_headers_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index[0])
                aslc_pkg::CFG_KEEP_HEADER:       keep_header_reg       <= cfg_data[0];
                aslc_pkg::CFG_KEEP_MAIL_HEADERS: keep_mail_headers_reg <= cfg_data[0];
            endcase
        end
    end

    aslc_line_eval #(
        .LINE_MAX(LINE_MAX)
    ) u_line_eval (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_accept         (in_accept),
        .data_byte         (s_tdata),
        .stream_end        (s_tuser[0]),
        .new_stream        (s_tuser[1]),
        .keep_header       (keep_header_reg),
        .keep_mail_headers (keep_mail_headers_reg),
        .push              (push)
    );

    aslc_result_queue u_result_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // Result item packing
    assign m_tdata = {4'b0000, out_res.verdict};
    assign m_tuser = out_res.copy;
    assign m_tlast = out_res.last;

endmodule

`default_nettype wire

// File: tb/sv/aslc_line_checker.sv
// Line verdict checker for the archive start line classifier: predicts every result
// from the input and configuration channels and compares it with the result channel.
// Depends on aslc_pkg for the verdict, phase and register index codes.
`timescale 1ns / 1ps

module aslc_line_checker
    import aslc_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [1:0]  s_tuser,   // [0] stream_end, [1] new_stream
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [7:0]  m_tdata,   // [3:0] line_verdict, [7:4] zero
    input  wire logic [0:0]  m_tuser,   // [0] copy_to_header
    input  wire logic        m_tlast,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [0:0]  cfg_data,
    output int               fail_count,
    output int               open_results
);

    // Prefix slots: C code 0..8, Pascal, bare hash, colon, echo, sed, cat, dashes
    localparam int IX_C_LAST = 8;
    localparam int IX_PASCAL = 9;
    localparam int IX_HASH   = 10;
    localparam int IX_COLON  = 11;
    localparam int IX_CAT    = 14;
    localparam int IX_DASHES = 15;

    // Marker word bits
    localparam int FND_CUT  = 0;
    localparam int FND_TEAR = 1;
    localparam int FND_PAIR = 2;

    typedef struct packed {
        verdict_t verdict;
        logic     copy;
        logic     last;
    } line_result_t;

    line_result_t expected_lines [$];
    line_result_t want;

    // Predicted registers and state
    logic        keep_hdr, keep_mail;
    phase_t      ph;
    int unsigned line_pos;
    logic [15:0] pre_alive;
    logic        txt_only;
    logic [1:0]  troff;
    logic [2:0]  widx, walive, wfound;
    logic        in_mail;
    logic [1:0]  tag_st;
    logic        blank, zero_mark, lead_ok;

    function automatic string prefix_text(int i);
        case (i)
            0:       return "#include";
            1:       return "# include";
            2:       return "#define";
            3:       return "# define";
            4:       return "#ifdef";
            5:       return "# ifdef";
            6:       return "#ifndef";
            7:       return "# ifndef";
            8:       return "/*";
            9:       return "(*";
            10:      return "#";
            11:      return ":";
            12:      return "echo ";
            13:      return "sed ";
            14:      return "cat ";
            default: return "--------";
        endcase
    endfunction

    function automatic string marker_word(int i);
        case (i)
            0:       return "cut";
            1:       return "here";
            default: return "tear";
        endcase
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_tag_char(logic [7:0] c);
        return is_alpha(c) || (c >= "0" && c <= "9") || c == "-" || c == "_" || c == ".";
    endfunction

    function automatic logic is_prose(logic [7:0] c);
        return is_alpha(c) || c == " " || c == "\t" || c == "\n" || c == "," || c == ".";
    endfunction

    function automatic void clear_line_state();
        line_pos  = 0;
        pre_alive = 16'hFFFF;
        txt_only  = 1'b1;
        troff     = 2'd0;
        widx      = 3'd0;
        walive    = 3'b111;
        wfound    = 3'b000;
        tag_st    = 2'd0;
        blank     = 1'b1;
        zero_mark = 1'b0;
        lead_ok   = 1'b0;
    endfunction

    // A word just ended: record cut / here / tear and pairs of them
    function automatic void close_word();
        logic hit_cut, hit_here, hit_tear;
        hit_cut  = walive[0] && widx == 3'd3;
        hit_here = walive[1] && widx == 3'd4;
        hit_tear = walive[2] && widx == 3'd4;
        if (hit_cut) begin
            if (wfound[FND_CUT]) wfound[FND_PAIR] = 1'b1;
            wfound[FND_CUT] = 1'b1;
        end
        if (hit_here && (wfound[FND_CUT] || wfound[FND_TEAR])) wfound[FND_PAIR] = 1'b1;
        if (hit_tear) wfound[FND_TEAR] = 1'b1;
        widx   = 3'd0;
        walive = 3'b111;
    endfunction

    // Fold one visible character into the per-line trackers
    function automatic void absorb_char(logic [7:0] b);
        int         p;
        string      s;
        logic [7:0] ch;
        logic [7:0] lc;
        p = line_pos;
        if (p < 9) begin
            for (int i = 0; i < 16; i++) begin
                s = prefix_text(i);
                if (p < s.len()) begin
                    ch = s[p];
                    if (b != ch) pre_alive[i] = 1'b0;
                end
            end
        end
        // troff: dot, two letters, then a non-letter
        if (p == 0) troff = (b == ".") ? 2'd1 : 2'd0;
        else if (p == 1) troff = (troff == 2'd1 && is_alpha(b)) ? 2'd2 : 2'd0;
        else if (p == 2) troff = (troff == 2'd2 && is_alpha(b)) ? 2'd3 : 2'd0;
        else if (p == 3 && troff == 2'd3 && is_alpha(b)) troff = 2'd0;
        if (!(p == 0 && b == "#") && b != 8'h00 && !is_prose(b)) txt_only = 1'b0;
        // mail header tag: leading blank, or tag characters then a colon
        if (tag_st == 2'd0)
            tag_st = (b == " " || b == "\t") ? 2'd2 : (is_tag_char(b) ? 2'd1 : 2'd3);
        else if (tag_st == 2'd1)
            tag_st = is_tag_char(b) ? 2'd1 : ((b == ":") ? 2'd2 : 2'd3);
        if (is_alpha(b)) begin
            lc = b | 8'h20;
            for (int i = 0; i < 3; i++) begin
                s = marker_word(i);
                if (widx >= s.len()) begin
                    walive[i] = 1'b0;
                end else begin
                    ch = s[widx];
                    if (ch != lc) walive[i] = 1'b0;
                end
            end
            if (widx < 3'd7) widx++;
        end else begin
            close_word();
        end
        if (p == 0) begin
            blank   = (b == "\n");
            lead_ok = (b == "#" || b == ":" || (b >= "a" && b <= "z"));
        end
        if (b == 8'h00) zero_mark = 1'b1;
    endfunction

    function automatic logic prefix_hit(int i);
        string s;
        s = prefix_text(i);
        return pre_alive[i] && line_pos >= s.len();
    endfunction

    // Verdict on a completed line; also moves the phase and the mail flag
    function automatic verdict_t judge_line(output logic cp);
        verdict_t v;
        logic     c_code;
        v      = V_IGNORED;
        c_code = 1'b0;
        cp     = 1'b0;
        if (!zero_mark) close_word();
        case (ph)
            PH_SEARCH: begin
                for (int i = 0; i <= IX_C_LAST; i++) if (prefix_hit(i)) c_code = 1'b1;
                if (c_code) begin
                    v  = V_C_CODE;
                    ph = PH_DONE;
                end else if (prefix_hit(IX_PASCAL)) begin
                    v  = V_PASCAL;
                    ph = PH_DONE;
                end else if (troff == 2'd3) begin
                    v  = V_TROFF;
                    ph = PH_DONE;
                end else if ((prefix_hit(IX_HASH) && !txt_only) || prefix_hit(IX_COLON) ||
                             prefix_hit(IX_COLON + 1) || prefix_hit(IX_COLON + 2) ||
                             prefix_hit(IX_CAT)) begin
                    v  = V_SHELL_START;
                    ph = PH_BODY;
                end else if (prefix_hit(IX_DASHES) || wfound[FND_PAIR]) begin
                    v  = V_CUT;
                    ph = PH_CUT;
                end else begin
                    v = V_HEADER;
                    if (keep_hdr) begin
                        if (in_mail && tag_st != 2'd2) in_mail = 1'b0;
                        cp = !in_mail || keep_mail;
                    end
                end
            end
            PH_CUT: begin
                if (blank) begin
                    v = V_BLANK_AFTER;
                end else if (lead_ok) begin
                    v  = V_SHELL_START;
                    ph = PH_BODY;
                end else begin
                    v  = V_CUT_LIED;
                    ph = PH_DONE;
                end
            end
            PH_BODY: v = V_BODY;
            default: v = V_IGNORED;
        endcase
        clear_line_state();
        return v;
    endfunction

    // Expected results of one accepted item
    function automatic void classify_item(logic [7:0] b, logic at_end, logic fresh);
        line_result_t res [2];
        int           n;
        logic         cp;
        verdict_t     v;
        n = 0;
        if (fresh) begin
            ph      = PH_SEARCH;
            in_mail = 1'b1;
            clear_line_state();
        end
        if (at_end) begin
            if (line_pos > 0) begin
                v      = judge_line(cp);
                res[n] = '{v, cp, 1'b0};
                n++;
            end
            if (ph == PH_SEARCH) begin
                res[n] = '{V_NONE, 1'b0, 1'b0};
                n++;
            end else if (ph == PH_CUT) begin
                res[n] = '{V_NONE_AFTER_CUT, 1'b0, 1'b0};
                n++;
            end
            ph = PH_DONE;
            clear_line_state();
        end else begin
            if (!zero_mark) absorb_char(b);
            line_pos++;
            if (b == "\n" || line_pos >= LINE_MAX - 1) begin
                v      = judge_line(cp);
                res[n] = '{v, cp, 1'b0};
                n++;
            end
        end
        if (n > 0) res[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++) expected_lines.push_back(res[i]);
    endfunction

    initial begin
        fail_count   = 0;
        open_results = 0;
    end

    // Compare results first: an item accepted at this edge cannot have one out yet
    always @(posedge aclk) begin
        if (!aresetn) begin
            keep_hdr  = 1'b0;
            keep_mail = 1'b0;
            ph        = PH_SEARCH;
            in_mail   = 1'b1;
            clear_line_state();
            expected_lines.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_lines.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, got verdict %0d copy %0b last %0b",
                             $time, m_tdata, m_tuser[0], m_tlast);
                end else begin
                    want = expected_lines.pop_front();
                    if (m_tdata != {4'h0, want.verdict} || m_tuser[0] != want.copy ||
                        m_tlast != want.last) begin
                        fail_count++;
                        $display("%0t: result mismatch, expected verdict %0d copy %0b last %0b, got tdata %0d copy %0b last %0b",
                                 $time, want.verdict, want.copy, want.last,
                                 m_tdata, m_tuser[0], m_tlast);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_KEEP_HEADER) keep_hdr = cfg_data[0];
                else keep_mail = cfg_data[0];
            end
            if (s_tvalid && s_tready) classify_item(s_tdata, s_tuser[0], s_tuser[1]);
        end
        open_results = expected_lines.size();
    end

endmodule

// File: tb/sv/archive_start_line_classifier_unit_tb.sv
// Testbench top for the archive start line classifier: clock, reset, text stimulus,
// configuration writes and the final verdict. Depends on aslc_pkg, the RTL top
// and aslc_line_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module archive_start_line_classifier_unit_tb;
    import aslc_pkg::*;

    localparam int LINE_LEN = LINE_MAX_DEFAULT;
    // Whole run, the one line longer than the line limit included
    localparam int ITEM_BUDGET = 850;

    typedef struct packed {
        logic [7:0] data;
        logic       end_mark;
        logic       fresh;
    } text_item_t;

    typedef enum int {
        K_TEXT, K_MAIL, K_CONT, K_C, K_PASCAL, K_TROFF, K_SHELL, K_CUT,
        K_NOISE, K_BLANK, K_AFTER
    } line_kind_t;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic [1:0] s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [0:0] m_tuser;
    logic       m_tlast;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [0:0] cfg_index;
    logic [0:0] cfg_data;
    int         fail_count;
    int         open_results;

    text_item_t outgoing_bytes [$];
    logic       fresh_next;
    logic       gaps_on;
    logic       stall_on;
    int         items_sent;
    int         file_no;
    int         combo;

    archive_start_line_classifier_unit #(.LINE_MAX(LINE_LEN)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    aslc_line_checker #(.LINE_MAX(LINE_LEN)) u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .fail_count(fail_count), .open_results(open_results)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("Verification failed");
        $finish;
    end

    // Result side back-pressure
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= !(stall_on && $urandom_range(0, 99) < 24);
        end
    end

    // ---------------- text building ----------------

    function automatic void push_char(logic [7:0] c);
        outgoing_bytes.push_back('{c, 1'b0, fresh_next});
        fresh_next = 1'b0;
    endfunction

    function automatic void push_end();
        outgoing_bytes.push_back('{8'($urandom), 1'b1, fresh_next});
        fresh_next = 1'b0;
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) push_char(s[i]);
    endfunction

    function automatic logic [7:0] lower_char();
        return 8'h61 + 8'($urandom_range(0, 25));
    endfunction

    function automatic void push_word();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            push_char((i == 0 && $urandom_range(0, 4) == 0) ? (lower_char() & 8'hDF)
                                                              : lower_char());
    endfunction

    function automatic string c_prefix(int i);
        case (i)
            0:       return "#include";
            1:       return "# include";
            2:       return "#define";
            3:       return "# define";
            4:       return "#ifdef";
            5:       return "# ifdef";
            6:       return "#ifndef";
            7:       return "# ifndef";
            default: return "/*";
        endcase
    endfunction

    function automatic void push_line(line_kind_t kind);
        string s;
        int    n;
        case (kind)
            K_TEXT: begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) begin
                    push_word();
                    case ($urandom_range(0, 3))
                        0:       push_text(", ");
                        1:       push_text(".");
                        default: push_text(" ");
                    endcase
                end
                push_text("\n");
            end
            K_MAIL: begin
                push_word();
                if ($urandom_range(0, 2) == 0) begin
                    push_text($urandom_range(0, 1) ? "-" : "_");
                    push_char(8'h30 + 8'($urandom_range(0, 9)));
                    push_word();
                end
                push_text(": ");
                push_word();
                push_text("\n");
            end
            K_CONT: begin
                push_text($urandom_range(0, 1) ? " " : "\t");
                push_word();
                push_text("\n");
            end
            K_C: begin
                s = c_prefix($urandom_range(0, 8));
                // near misses drop the last character
                if ($urandom_range(0, 3) == 0) s = s.substr(0, s.len() - 2);
                push_text(s);
                push_text(" ");
                push_word();
                push_text("\n");
            end
            K_PASCAL: begin
                push_text("(*");
                push_word();
                push_text("\n");
            end
            K_TROFF: begin
                push_text(".");
                push_char(lower_char());
                if ($urandom_range(0, 4) != 0) push_char(lower_char() & 8'hDF);
                case ($urandom_range(0, 3))
                    0: push_text(" ");
                    1: push_char(lower_char());
                    2: push_char(8'h30 + 8'($urandom_range(0, 9)));
                    default: ;
                endcase
                push_text("\n");
            end
            K_SHELL: begin
                case ($urandom_range(0, 7))
                    0:       push_text(":");
                    1:       push_text("echo ");
                    2:       push_text("sed ");
                    3:       push_text("cat ");
                    4:       push_text("#!/bin/sh");
                    5:       push_text("# ");
                    6:       push_text("#x=");
                    default: push_text("echo");
                endcase
                push_word();
                push_text("\n");
            end
            K_CUT: begin
                case ($urandom_range(0, 9))
                    0:       push_text("--------");
                    1:       push_text("-------");
                    2:       push_text("--- cut here ---");
                    3:       push_text("tear here");
                    4:       push_text("Cut Cut");
                    5:       push_text("cut there");
                    6:       push_text("cutting here");
                    7:       push_text("TEAR-HERE");
                    8:       push_text("here cut");
                    default: begin
                        push_text("cut");
                        push_char(8'h00);
                        push_text(" here");
                    end
                endcase
                push_text("\n");
            end
            K_NOISE: begin
                n = $urandom_range(0, 10);
                for (int i = 0; i < n; i++) begin
                    case ($urandom_range(0, 9))
                        0:       push_char(8'h00);
                        1:       push_char(8'h80 | 8'($urandom));
                        default: push_char(8'($urandom));
                    endcase
                end
                push_text("\n");
            end
            K_BLANK: push_text("\n");
            default: begin
                // first line after a cut marker
                case ($urandom_range(0, 5))
                    0:       push_text("#");
                    1:       push_text(":");
                    2:       push_char(lower_char());
                    3:       push_char(lower_char() & 8'hDF);
                    4:       push_char(8'h30 + 8'($urandom_range(0, 9)));
                    default: push_text(" ");
                endcase
                push_word();
                push_text("\n");
            end
        endcase
    endfunction

    // One file: preamble, a start line or none, what follows it, then the ending
    function automatic void build_file(logic with_long_line);
        int         n;
        line_kind_t start;
        fresh_next = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 19) == 0) begin
            fresh_next = 1'b1;
            push_end();
            return;
        end
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) push_line(K_NOISE);
        end else begin
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) push_line(($urandom_range(0, 2) == 0) ? K_CONT : K_MAIL);
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 4))
                    0:       push_line(K_TEXT);
                    1:       push_line(K_BLANK);
                    2:       push_line(K_NOISE);
                    3:       push_line(K_MAIL);
                    default: push_line(K_TEXT);
                endcase
            end
            if (with_long_line) begin
                for (int i = 0; i < LINE_LEN + 3; i++)
                    push_char(($urandom_range(0, 5) == 0) ? 8'h20 : lower_char());
                push_text("\n");
            end
            case ($urandom_range(0, 6))
                0:       start = K_C;
                1:       start = K_PASCAL;
                2:       start = K_TROFF;
                3:       start = K_SHELL;
                6:       start = K_TEXT;
                default: start = K_CUT;
            endcase
            push_line(start);
            if (start == K_CUT) begin
                n = $urandom_range(0, 2);
                for (int i = 0; i < n; i++) push_line(K_BLANK);
                if ($urandom_range(0, 9) < 7) push_line(K_AFTER);
            end
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) push_line(($urandom_range(0, 3) == 0) ? K_NOISE : K_TEXT);
        end
        case ($urandom_range(0, 19))
            0, 1, 2: begin
                // unfinished line at the end of the stream
                push_word();
                push_end();
            end
            3, 4, 5: ;
            default: push_end();
        endcase
    endfunction

    // ---------------- channel drivers (called at a falling edge) ----------------

    task automatic send_item(text_item_t it);
        while (gaps_on && $urandom_range(0, 99) < 24) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it.data;
        s_tuser  <= {it.fresh, it.end_mark};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic send_queued();
        while (outgoing_bytes.size() > 0) send_item(outgoing_bytes.pop_front());
    endtask

    task automatic write_reg(logic [0:0] idx, logic [0:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    // Wait for every expected result, then let a mid-line item drain through
    task automatic settle();
        s_tvalid <= 1'b0;
        while (open_results != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic apply_config(int setting);
        write_reg(CFG_KEEP_HEADER, setting[0]);
        write_reg(CFG_KEEP_MAIL_HEADERS, setting[1]);
        cfg_valid <= 1'b0;
    endtask

    // ---------------- main sequence ----------------

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'h00;
        s_tuser    = 2'b00;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_KEEP_HEADER;
        cfg_data   = 1'b0;
        fresh_next = 1'b0;
        gaps_on    = 1'b1;
        stall_on   = 1'b1;
        items_sent = 0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        apply_config(1);

        // Directed: extreme bytes with a zero byte, Pascal, ignored line, end after
        // rejection, partial line at end, new stream together with end, cut sequence
        fresh_next = 1'b1;
        push_char(8'hFF);
        push_char(8'h00);
        push_text("\n(*\nx\n");
        push_end();
        fresh_next = 1'b1;
        push_text("a");
        push_end();
        fresh_next = 1'b1;
        push_end();
        fresh_next = 1'b1;
        push_text("--------\n\nQ\n");
        push_end();
        send_queued();

        // Random files, cycling through all register settings
        combo   = 2;
        file_no = 0;
        while (items_sent < ITEM_BUDGET) begin
            if (file_no % 2 == 1) begin
                settle();
                apply_config(combo % 4);
                combo++;
            end
            // a stretch with neither side idling
            gaps_on  = !(file_no >= 2 && file_no < 5);
            stall_on = gaps_on;
            build_file(file_no == 3);
            send_queued();
            file_no++;
        end

        s_tvalid <= 1'b0;
        while (open_results != 0) @(negedge aclk);
        repeat (16) @(negedge aclk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
